// ===== design/agf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agf_pkg
// Shared types and constants of the arm gravity feedforward block: register
// indexes, mode codes, phase scale factors, CORDIC table and saturation.
// ----------------------------------------------------------------------------
package agf_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_PROX_ZERO           = 3'd0,
      CSR_DIST_ZERO           = 3'd1,
      CSR_PROX_REF            = 3'd2,
      CSR_DIST_REF            = 3'd3,
      CSR_DIST_GAIN_LIGHT     = 3'd4,
      CSR_DIST_GAIN_LOADED    = 3'd5,
      CSR_STRETCH_GAIN_LIGHT  = 3'd6,
      CSR_STRETCH_GAIN_LOADED = 3'd7
   } csr_index_type;

   // load mode codes, the other two codes hold the last result
   localparam logic [1:0] MODE_LIGHT  = 2'd0;
   localparam logic [1:0] MODE_LOADED = 2'd1;

   // widths of the exact angle sums and of the Q30 CORDIC datapath
   localparam int ANGLE_W = 36;
   localparam int Q30_W   = 34;

   // angle to phase scale, 2^-32 turn units, split at bit 20 for the multipliers
   localparam logic [37:0] K_RAD = 38'd174992710548;
   localparam logic [37:0] K_DEG = 38'd3054198966;
   localparam int          K_SPLIT = 20;

   // floor(2^34 / 25), used for the divide by 100 of the light distal term
   localparam logic [29:0] RECIP_25 = 30'd687194767;

   localparam int                      CORDIC_ITERS = 30;
   localparam logic signed [Q30_W-1:0] CORDIC_X0    = 34'sd652032874;
   // init stage, one stage per iteration, one stage for the half-turn fold back
   localparam int                      CORDIC_LAT   = CORDIC_ITERS + 2;

   localparam logic [31:0] ATAN_TURN [0:CORDIC_ITERS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== design/agf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agf_if
// Valid/ready channels of the arm gravity feedforward block: the position
// request and the drive value response.
// ----------------------------------------------------------------------------
interface agf_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [31:0] proximal_position;
   logic signed [31:0] distal_angle;
   logic signed [31:0] stretch_position;
   logic signed [31:0] rotor_angle_deg;

   modport source (output valid, mode, proximal_position, distal_angle,
                   stretch_position, rotor_angle_deg, input ready);
   modport sink   (input valid, mode, proximal_position, distal_angle,
                   stretch_position, rotor_angle_deg, output ready);
endinterface

interface agf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] distal_torque;
   logic signed [31:0] proximal_torque;
   logic signed [31:0] stretch_force;
   logic signed [31:0] rotor_torque;

   modport source (output valid, distal_torque, proximal_torque, stretch_force,
                   rotor_torque, input ready);
   modport sink   (input valid, distal_torque, proximal_torque, stretch_force,
                   rotor_torque, output ready);
endinterface

// ===== design/agf_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agf_cordic
// Pipelined rotation-mode CORDIC: 32-bit phase in, Q30 cosine and sine out,
// one iteration per register stage, one phase per cycle while en is high.
// ----------------------------------------------------------------------------
module agf_cordic import agf_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic [31:0]               phase,
   output logic signed [Q30_W-1:0]   cos_q30,
   output logic signed [Q30_W-1:0]   sin_q30
);

   logic signed [Q30_W-1:0] x_ff    [0:CORDIC_ITERS];
   logic signed [Q30_W-1:0] y_ff    [0:CORDIC_ITERS];
   logic signed [Q30_W-1:0] z_ff    [0:CORDIC_ITERS];
   logic                    flip_ff [0:CORDIC_ITERS];
   logic signed [Q30_W-1:0] cos_ff, sin_ff;
   logic [31:0]             quad;
   logic                    flip_in;
   logic [31:0]             turned;

   // fold the left half-plane by half a turn
   always_comb begin
      quad    = phase + 32'h4000_0000;
      flip_in = quad[31];
      turned  = flip_in ? (phase + 32'h8000_0000) : phase;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= Q30_W'($signed(turned));
         flip_ff[0] <= flip_in;
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      logic signed [Q30_W-1:0] dx, dy, at;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign at = $signed({2'b00, ATAN_TURN[i]});

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][Q30_W-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + at;
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   // undo the half-turn fold
   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= flip_ff[CORDIC_ITERS] ? -x_ff[CORDIC_ITERS] : x_ff[CORDIC_ITERS];
         sin_ff <= flip_ff[CORDIC_ITERS] ? -y_ff[CORDIC_ITERS] : y_ff[CORDIC_ITERS];
      end
   end

   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

// ===== design/arm_gravity_feedforward.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_gravity_feedforward
// Gravity compensation drive values for a four-axis arm from joint positions,
// fixed point with FRAC_BITS fractional bits, three pipelined CORDIC units.
//
//   channel  direction  contents
//   req_if   in         mode, proximal/distal/stretch positions, rotor degrees
//   rsp_if   out        distal, proximal, stretch, rotor drive values
//   csr_*    in         write enable, 3-bit register index, 32-bit data
//
// One item enters per cycle while the response is not stalled; a result passes
// through the input stages, the 32-stage CORDIC units and the multiply stages.
// Synchronous reset clears the valid bits, the registers to their calibration
// values and the held result to zero. A stalled response freezes the whole
// pipeline, and request ready is low only while the response register is full
// and not taken.
// ----------------------------------------------------------------------------
module arm_gravity_feedforward import agf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   agf_req_if.sink     req_if,
   agf_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // widths that follow from the fraction size
   localparam int NW = ((FRAC_BITS + 17 > 38) ? FRAC_BITS + 17 : 38) + 2;
   localparam int XW = NW - 5;
   localparam int MW = XW - 11;
   localparam int FW = MW + 1;
   localparam int GW = (FRAC_BITS + 12 > 32) ? FRAC_BITS + 12 : 32;
   localparam int TW = FW + 33;

   localparam longint ONE = longint'(1) << FRAC_BITS;
   localparam logic signed [31:0] PROX_REF_RESET  = 32'((1944 * ONE + 500) / 1000);
   localparam logic signed [31:0] DIST_REF_RESET  = 32'(-((2522 * ONE + 500) / 1000));
   localparam logic signed [31:0] DGAIN_LT_RESET  = 32'((30 * ONE + 50) / 100);
   localparam logic signed [31:0] DGAIN_LD_RESET  = 32'((278 * ONE + 50) / 100);
   localparam logic signed [GW-1:0] SGAIN_LT_RESET = GW'(425 * ONE);
   localparam logic signed [GW-1:0] SGAIN_LD_RESET = GW'(1200 * ONE);

   localparam logic signed [NW-1:0] BA_LIGHT  = NW'(52000 * ONE);
   localparam logic signed [NW-1:0] BA_LOADED = NW'(100000 * ONE);
   localparam logic signed [NW-1:0] BC_LOADED = NW'(4000 * ONE);
   localparam logic [MW-1:0] RECIP_3125 = MW'((longint'(1) << XW) / 3125);

   typedef struct packed {
      logic                 v;
      logic [1:0]           mode;
      logic signed [FW-1:0] fa;
      logic signed [FW-1:0] fc;
   } side_type;

   // configuration registers
   logic signed [31:0]   prox_zero_ff, dist_zero_ff, prox_ref_ff, dist_ref_ff;
   logic signed [31:0]   dgain_lt_ff, dgain_ld_ff;
   logic signed [GW-1:0] sgain_lt_ff, sgain_ld_ff;

   logic en;

   // stage 1
   logic                      v1_ff;
   logic [1:0]                mode1_ff;
   logic signed [ANGLE_W-1:0] a1_ff, d1_ff, a_in, d_in;
   logic signed [31:0]        rd1_ff;
   logic signed [NW-1:0]      na1_ff, nc1_ff, na_in, nc_in, s_ext;

   // stage 2
   logic                      v2_ff;
   logic [1:0]                mode2_ff;
   logic signed [56:0]        alo2_ff, dlo2_ff;
   logic signed [54:0]        ahi2_ff, dhi2_ff;
   logic signed [52:0]        rlo2_ff;
   logic signed [50:0]        rhi2_ff;
   logic [XW-1:0]             xa2_ff, xc2_ff;
   logic                      nega2_ff, negc2_ff;
   logic [NW-1:0]             maga, magc;

   // stage 3
   logic                      v3_ff;
   logic [1:0]                mode3_ff;
   logic [31:0]               pha3_ff, phd3_ff, phr3_ff;
   logic [XW-1:0]             xa3_ff, xc3_ff;
   logic [XW+MW-1:0]          pqa3_ff, pqc3_ff;
   logic                      nega3_ff, negc3_ff;
   logic [63:0]               suma, sumd, sumr;

   // stage 4 correction of the divide by 100000
   logic [MW-1:0]             qa, qc, qa_fix, qc_fix;
   logic [XW-1:0]             ra, rc;
   side_type                  side_in;
   side_type                  side_ff [0:CORDIC_LAT-1];

   logic signed [Q30_W-1:0]   ca, sa, cd, sd, cr, sr;

   // stage 36 products
   logic                      v36_ff;
   logic [1:0]                mode36_ff;
   logic signed [FW-1:0]      fc36_ff;
   logic signed [65:0]        pd36_ff;
   logic signed [FW+33:0]     pa36_ff;
   logic signed [GW+33:0]     ps36_ff;
   logic signed [44:0]        pr36_ff;

   // stage 37 rounding
   logic                      v37_ff;
   logic [1:0]                mode37_ff;
   logic signed [FW-1:0]      fc37_ff;
   logic signed [31:0]        dt37_ff, st37_ff, rt37_ff;
   logic signed [FW+3:0]      ta37_ff;
   logic signed [65:0]        pd_r;
   logic signed [FW+33:0]     pa_r;
   logic signed [GW+33:0]     ps_r;
   logic signed [44:0]        pr_r;

   // stage 38
   logic                      v38_ff;
   logic [1:0]                mode38_ff;
   logic signed [FW+31:0]     pc38_ff;
   logic [33:0]               x038_ff;
   logic                      neg038_ff;
   logic signed [31:0]        dt38_ff, st38_ff, rt38_ff;
   logic signed [FW+3:0]      ta38_ff;
   logic [31:0]               absdt;
   logic [35:0]               m0;

   // stage 39
   logic                      v39_ff;
   logic [1:0]                mode39_ff;
   logic signed [FW+31:0]     tc39_ff;
   logic [63:0]               q0p39_ff;
   logic [33:0]               x039_ff;
   logic                      neg039_ff;
   logic signed [31:0]        dt39_ff, st39_ff, rt39_ff;
   logic signed [FW+3:0]      ta39_ff;

   // stage 40
   logic                      v40_ff;
   logic [1:0]                mode40_ff;
   logic signed [TW-1:0]      term40_ff, term_in;
   logic signed [31:0]        dt40_ff, st40_ff, rt40_ff;
   logic signed [FW+3:0]      ta40_ff;
   logic [29:0]               q0, q0_fix;
   logic [33:0]               r0;

   // response register, also the held result
   logic                      rsp_valid_ff;
   logic signed [31:0]        out_dt_ff, out_pt_ff, out_st_ff, out_rt_ff;
   logic signed [63:0]        prox_sum;

   // pipeline advances whenever the response register can take a value
   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prox_zero_ff <= '0;
         dist_zero_ff <= '0;
         prox_ref_ff  <= PROX_REF_RESET;
         dist_ref_ff  <= DIST_REF_RESET;
         dgain_lt_ff  <= DGAIN_LT_RESET;
         dgain_ld_ff  <= DGAIN_LD_RESET;
         sgain_lt_ff  <= SGAIN_LT_RESET;
         sgain_ld_ff  <= SGAIN_LD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROX_ZERO:           prox_zero_ff <= csr_wdata;
            CSR_DIST_ZERO:           dist_zero_ff <= csr_wdata;
            CSR_PROX_REF:            prox_ref_ff  <= csr_wdata;
            CSR_DIST_REF:            dist_ref_ff  <= csr_wdata;
            CSR_DIST_GAIN_LIGHT:     dgain_lt_ff  <= csr_wdata;
            CSR_DIST_GAIN_LOADED:    dgain_ld_ff  <= csr_wdata;
            CSR_STRETCH_GAIN_LIGHT:  sgain_lt_ff  <= GW'($signed(csr_wdata));
            CSR_STRETCH_GAIN_LOADED: sgain_ld_ff  <= GW'($signed(csr_wdata));
            default:                 ;
         endcase
      end
   end

   // stage 1: joint angles and factor numerators
   always_comb begin
      a_in  = ANGLE_W'(prox_ref_ff) - ANGLE_W'(req_if.proximal_position)
              + ANGLE_W'(prox_zero_ff);
      d_in  = ANGLE_W'(req_if.distal_angle) - ANGLE_W'(dist_zero_ff)
              - ANGLE_W'(dist_ref_ff) + a_in;
      s_ext = NW'(req_if.stretch_position);
      if (req_if.mode == MODE_LOADED) begin
         na_in = NW'(-82) * s_ext - BA_LOADED;
      end else begin
         na_in = NW'(-35) * s_ext - BA_LIGHT;
      end
      nc_in = NW'(-5) * s_ext - BC_LOADED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff <= req_if.mode;
         a1_ff    <= a_in;
         d1_ff    <= d_in;
         rd1_ff   <= req_if.rotor_angle_deg;
         na1_ff   <= na_in;
         nc1_ff   <= nc_in;
      end
   end

   // stage 2: phase partial products, magnitudes plus half of 100000, over 32
   always_comb begin
      maga = na1_ff[NW-1] ? NW'(-na1_ff) : NW'(na1_ff);
      magc = nc1_ff[NW-1] ? NW'(-nc1_ff) : NW'(nc1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode2_ff <= mode1_ff;
         alo2_ff  <= a1_ff * $signed({1'b0, K_RAD[K_SPLIT-1:0]});
         ahi2_ff  <= a1_ff * $signed({1'b0, K_RAD[37:K_SPLIT]});
         dlo2_ff  <= d1_ff * $signed({1'b0, K_RAD[K_SPLIT-1:0]});
         dhi2_ff  <= d1_ff * $signed({1'b0, K_RAD[37:K_SPLIT]});
         rlo2_ff  <= rd1_ff * $signed({1'b0, K_DEG[K_SPLIT-1:0]});
         rhi2_ff  <= rd1_ff * $signed({1'b0, K_DEG[37:K_SPLIT]});
         xa2_ff   <= XW'((maga + NW'(50000)) >> 5);
         xc2_ff   <= XW'((magc + NW'(50000)) >> 5);
         nega2_ff <= na1_ff[NW-1];
         negc2_ff <= nc1_ff[NW-1];
      end
   end

   // stage 3: phases, reciprocal products
   always_comb begin
      suma = 64'(alo2_ff) + (64'(ahi2_ff) << K_SPLIT);
      sumd = 64'(dlo2_ff) + (64'(dhi2_ff) << K_SPLIT);
      sumr = 64'(rlo2_ff) + (64'(rhi2_ff) << K_SPLIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode3_ff <= mode2_ff;
         pha3_ff  <= suma[FRAC_BITS+39:FRAC_BITS+8];
         phd3_ff  <= sumd[FRAC_BITS+39:FRAC_BITS+8];
         phr3_ff  <= sumr[FRAC_BITS+39:FRAC_BITS+8];
         xa3_ff   <= xa2_ff;
         xc3_ff   <= xc2_ff;
         pqa3_ff  <= xa2_ff * RECIP_3125;
         pqc3_ff  <= xc2_ff * RECIP_3125;
         nega3_ff <= nega2_ff;
         negc3_ff <= negc2_ff;
      end
   end

   // stage 4: quotient correction, signs restored
   always_comb begin
      qa      = pqa3_ff[XW+MW-1:XW];
      qc      = pqc3_ff[XW+MW-1:XW];
      ra      = xa3_ff - XW'(qa * 12'd3125);
      rc      = xc3_ff - XW'(qc * 12'd3125);
      qa_fix  = (ra >= XW'(3125)) ? qa + 1'b1 : qa;
      qc_fix  = (rc >= XW'(3125)) ? qc + 1'b1 : qc;
      side_in.v    = v3_ff;
      side_in.mode = mode3_ff;
      side_in.fa   = nega3_ff ? -$signed({1'b0, qa_fix}) : $signed({1'b0, qa_fix});
      side_in.fc   = negc3_ff ? -$signed({1'b0, qc_fix}) : $signed({1'b0, qc_fix});
   end

   // side payload travels alongside the CORDIC units
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_LAT; k++) begin
            side_ff[k] <= '0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < CORDIC_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   agf_cordic u_cordic_prox (
      .clock   (clock),
      .en      (en),
      .phase   (pha3_ff),
      .cos_q30 (ca),
      .sin_q30 (sa)
   );

   agf_cordic u_cordic_dist (
      .clock   (clock),
      .en      (en),
      .phase   (phd3_ff),
      .cos_q30 (cd),
      .sin_q30 (sd)
   );

   agf_cordic u_cordic_rotor (
      .clock   (clock),
      .en      (en),
      .phase   (phr3_ff),
      .cos_q30 (cr),
      .sin_q30 (sr)
   );

   // stage 36: gain products
   always_ff @(posedge clock) begin
      if (reset) begin
         v36_ff <= 1'b0;
      end else if (en) begin
         v36_ff <= side_ff[CORDIC_LAT-1].v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode36_ff <= side_ff[CORDIC_LAT-1].mode;
         fc36_ff   <= side_ff[CORDIC_LAT-1].fc;
         pd36_ff   <= ((side_ff[CORDIC_LAT-1].mode == MODE_LOADED) ? dgain_ld_ff
                                                                   : dgain_lt_ff) * cd;
         pa36_ff   <= side_ff[CORDIC_LAT-1].fa * ca;
         ps36_ff   <= ((side_ff[CORDIC_LAT-1].mode == MODE_LOADED) ? sgain_ld_ff
                                                                   : sgain_lt_ff) * sa;
         pr36_ff   <= sr * 11'sd800;
      end
   end

   // stage 37: round out of Q30, saturate the distal, stretch and rotor terms
   always_comb begin
      pd_r = (pd36_ff + 66'sd536870912) >>> 30;
      pa_r = (pa36_ff + (FW+34)'(536870912)) >>> 30;
      ps_r = (ps36_ff + (GW+34)'(536870912)) >>> 30;
      pr_r = (pr36_ff + 45'(longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v37_ff <= 1'b0;
      end else if (en) begin
         v37_ff <= v36_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode37_ff <= mode36_ff;
         fc37_ff   <= fc36_ff;
         dt37_ff   <= sat32($signed(pd_r[63:0]));
         ta37_ff   <= pa_r[FW+3:0];
         st37_ff   <= sat32($signed(ps_r[63:0]));
         rt37_ff   <= sat32(64'(pr_r));
      end
   end

   // stage 38: loaded distal factor product, light distal magnitude
   always_comb begin
      absdt = dt37_ff[31] ? 32'(-dt37_ff) : 32'(dt37_ff);
      m0    = 36'(absdt) * 36'd11 + 36'd50;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v38_ff <= 1'b0;
      end else if (en) begin
         v38_ff <= v37_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode38_ff <= mode37_ff;
         pc38_ff   <= fc37_ff * dt37_ff;
         x038_ff   <= m0[35:2];
         neg038_ff <= (dt37_ff > 32'sd0);
         dt38_ff   <= dt37_ff;
         st38_ff   <= st37_ff;
         rt38_ff   <= rt37_ff;
         ta38_ff   <= ta37_ff;
      end
   end

   // stage 39: loaded term rounding, light term reciprocal product
   always_ff @(posedge clock) begin
      if (reset) begin
         v39_ff <= 1'b0;
      end else if (en) begin
         v39_ff <= v38_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode39_ff <= mode38_ff;
         tc39_ff   <= (pc38_ff + (FW+32)'(longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
         q0p39_ff  <= x038_ff * RECIP_25;
         x039_ff   <= x038_ff;
         neg039_ff <= neg038_ff;
         dt39_ff   <= dt38_ff;
         st39_ff   <= st38_ff;
         rt39_ff   <= rt38_ff;
         ta39_ff   <= ta38_ff;
      end
   end

   // stage 40: light term correction and mode select
   always_comb begin
      q0     = q0p39_ff[63:34];
      r0     = x039_ff - 34'(q0 * 5'd25);
      q0_fix = (r0 >= 34'd25) ? q0 + 1'b1 : q0;
      if (mode39_ff == MODE_LOADED) begin
         term_in = TW'(tc39_ff);
      end else begin
         term_in = neg039_ff ? -TW'($signed({1'b0, q0_fix}))
                             : TW'($signed({1'b0, q0_fix}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v40_ff <= 1'b0;
      end else if (en) begin
         v40_ff <= v39_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode40_ff <= mode39_ff;
         term40_ff <= term_in;
         dt40_ff   <= dt39_ff;
         st40_ff   <= st39_ff;
         rt40_ff   <= rt39_ff;
         ta40_ff   <= ta39_ff;
      end
   end

   // response register: loads in active modes, keeps the held result otherwise
   assign prox_sum = 64'(ta40_ff) + 64'(term40_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         out_dt_ff    <= '0;
         out_pt_ff    <= '0;
         out_st_ff    <= '0;
         out_rt_ff    <= '0;
      end else if (en) begin
         rsp_valid_ff <= v40_ff;
         if (v40_ff && (mode40_ff == MODE_LIGHT || mode40_ff == MODE_LOADED)) begin
            out_dt_ff <= dt40_ff;
            out_pt_ff <= sat32(prox_sum);
            out_st_ff <= st40_ff;
            out_rt_ff <= rt40_ff;
         end
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.distal_torque   = out_dt_ff;
   assign rsp_if.proximal_torque = out_pt_ff;
   assign rsp_if.stretch_force   = out_st_ff;
   assign rsp_if.rotor_torque    = out_rt_ff;

endmodule

// ===== design/agf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agf_checker
// Port-level checks of the arm gravity feedforward block, bound to the top.
// ----------------------------------------------------------------------------
module agf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_distal_torque,
   input logic [31:0] rsp_proximal_torque,
   input logic [31:0] rsp_stretch_force,
   input logic [31:0] rsp_rotor_torque
);

   // a stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distal_torque)
         && $stable(rsp_proximal_torque) && $stable(rsp_stretch_force)
         && $stable(rsp_rotor_torque))
      else $error("stalled response changed");

   // requests are taken exactly when the response slot can move
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response slot");

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // handshake outputs are always known once out of reset
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid}))
      else $error("handshake output unknown");

endmodule

bind arm_gravity_feedforward agf_checker u_agf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_distal_torque   (rsp_if.distal_torque),
   .rsp_proximal_torque (rsp_if.proximal_torque),
   .rsp_stretch_force   (rsp_if.stretch_force),
   .rsp_rotor_torque    (rsp_if.rotor_torque)
);
